// ----- rtl/lcpm_pkg.sv -----
// Shared types and constants of the level-crossing period meter.
package lcpm_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned COUNT_BITS    = 24;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned PERIOD_BITS   = TIME_BITS + FRAC_BITS;
  localparam int unsigned EDGE_BITS     = COUNT_BITS;
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = SAMPLE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MEASURE_MODE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_LEVEL = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_HYST_LOW      = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_HYST_HIGH     = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [TIME_BITS-1:0]   sample_time;
    logic                          last_sample;
  } lcpm_in_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] mean_period;
    logic [PERIOD_BITS-1:0] rise_period;
    logic [PERIOD_BITS-1:0] fall_period;
    logic [EDGE_BITS-1:0]   rise_edges;
    logic [EDGE_BITS-1:0]   fall_edges;
    logic                   period_valid;
  } lcpm_out_t;

  // One finished record, waiting for its divisions.
  typedef struct packed {
    logic                  hyst;
    logic [TIME_BITS-1:0]  rise_diff;
    logic [COUNT_BITS-1:0] rise_cnt;
    logic [TIME_BITS-1:0]  fall_diff;
    logic [COUNT_BITS-1:0] fall_cnt;
  } lcpm_job_t;

endpackage

// ----- rtl/lcpm_front.sv -----
// Front end: configuration registers, crossing detection and record accumulation.
module lcpm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [lcpm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [lcpm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  input  lcpm_pkg::lcpm_in_t                   in_data_i,
  input  logic                                 queue_full_i,
  output logic                                 push_o,
  output lcpm_pkg::lcpm_job_t                  job_o
);
  import lcpm_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                          mode_q;
  logic signed [SAMPLE_BITS-1:0] trig_q, hyst_lo_q, hyst_hi_q;

  logic                          have_prev_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic                          comp_q, comp_d;
  logic [TIME_BITS-1:0]          rise_first_q, rise_first_d, rise_last_q, rise_last_d;
  logic [TIME_BITS-1:0]          fall_first_q, fall_first_d, fall_last_q, fall_last_d;
  logic [COUNT_BITS-1:0]         rise_cnt_q, rise_cnt_d, fall_cnt_q, fall_cnt_d;
  logic                          rise_edge, fall_edge, accept;

  assign accept = in_valid_i && !queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      trig_q    <= '0;
      hyst_lo_q <= '0;
      hyst_hi_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MEASURE_MODE:  mode_q    <= cfg_data_i[0];
        CFG_TRIGGER_LEVEL: trig_q    <= cfg_data_i;
        CFG_HYST_LOW:      hyst_lo_q <= cfg_data_i;
        CFG_HYST_HIGH:     hyst_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    comp_d    = comp_q;
    rise_edge = 1'b0;
    fall_edge = 1'b0;
    if (mode_q) begin
      // high threshold wins when the thresholds are crossed over
      if (in_data_i.sample > hyst_hi_q) begin
        comp_d = 1'b1;
      end else if (in_data_i.sample < hyst_lo_q) begin
        comp_d = 1'b0;
      end
      rise_edge = have_prev_q && !comp_q && comp_d;
    end else begin
      rise_edge = have_prev_q && (prev_q <= trig_q) && (in_data_i.sample > trig_q);
      fall_edge = have_prev_q && (prev_q >= trig_q) && (in_data_i.sample < trig_q);
    end
  end

  always_comb begin
    rise_first_d = rise_first_q;
    rise_last_d  = rise_last_q;
    rise_cnt_d   = rise_cnt_q;
    fall_first_d = fall_first_q;
    fall_last_d  = fall_last_q;
    fall_cnt_d   = fall_cnt_q;
    if (rise_edge) begin
      if (rise_cnt_q == '0) begin
        rise_first_d = in_data_i.sample_time;
      end
      rise_last_d = in_data_i.sample_time;
      if (rise_cnt_q != CNT_MAX) begin
        rise_cnt_d = rise_cnt_q + 1'b1;
      end
    end
    if (fall_edge) begin
      if (fall_cnt_q == '0) begin
        fall_first_d = in_data_i.sample_time;
      end
      fall_last_d = in_data_i.sample_time;
      if (fall_cnt_q != CNT_MAX) begin
        fall_cnt_d = fall_cnt_q + 1'b1;
      end
    end
  end

  assign push_o          = accept && in_data_i.last_sample;
  assign job_o.hyst      = mode_q;
  assign job_o.rise_diff = rise_last_d - rise_first_d;
  assign job_o.rise_cnt  = rise_cnt_d;
  assign job_o.fall_diff = fall_last_d - fall_first_d;
  assign job_o.fall_cnt  = fall_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_q       <= '0;
      comp_q       <= 1'b0;
      rise_first_q <= '0;
      rise_last_q  <= '0;
      rise_cnt_q   <= '0;
      fall_first_q <= '0;
      fall_last_q  <= '0;
      fall_cnt_q   <= '0;
    end else if (accept) begin
      if (in_data_i.last_sample) begin
        have_prev_q  <= 1'b0;
        prev_q       <= '0;
        comp_q       <= 1'b0;
        rise_first_q <= '0;
        rise_last_q  <= '0;
        rise_cnt_q   <= '0;
        fall_first_q <= '0;
        fall_last_q  <= '0;
        fall_cnt_q   <= '0;
      end else begin
        have_prev_q  <= 1'b1;
        prev_q       <= in_data_i.sample;
        comp_q       <= comp_d;
        rise_first_q <= rise_first_d;
        rise_last_q  <= rise_last_d;
        rise_cnt_q   <= rise_cnt_d;
        fall_first_q <= fall_first_d;
        fall_last_q  <= fall_last_d;
        fall_cnt_q   <= fall_cnt_d;
      end
    end
  end

endmodule

// ----- rtl/lcpm_fifo.sv -----
// Small queue of finished records between the front end and the divider.
module lcpm_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  lcpm_pkg::lcpm_job_t                  push_data_i,
  input  logic                                 pop_i,
  output lcpm_pkg::lcpm_job_t                  pop_data_o,
  output logic                                 full_o,
  output logic                                 empty_o,
  output logic [$clog2(DEPTH+1)-1:0]           count_o
);
  import lcpm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcpm_job_t           mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lcpm_back.sv -----
// Back end: serial divider for both mean periods and the result register.
module lcpm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_avail_i,
  input  lcpm_pkg::lcpm_job_t    job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lcpm_pkg::lcpm_out_t    out_data_o
);
  import lcpm_pkg::*;

  localparam int unsigned STEP_W = $clog2(PERIOD_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PERIOD_BITS - 1);
  localparam logic [COUNT_BITS-1:0] TWO = COUNT_BITS'(2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RISE = 4'b0010,
    ST_FALL = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_e;

  back_state_e             state_q, state_d;
  lcpm_job_t               job_q;
  logic [PERIOD_BITS-1:0]  div_q, div_next;
  logic [COUNT_BITS-1:0]   rem_q, rem_next, divisor;
  logic [COUNT_BITS:0]     shifted;
  logic                    ge;
  logic [STEP_W-1:0]       step_q;
  logic [PERIOD_BITS-1:0]  rise_quo_q, fall_quo_q;
  logic                    out_valid_q, load_out;
  lcpm_out_t               out_q, result;
  logic                    rise_ok, fall_ok, res_valid;
  logic [PERIOD_BITS-1:0]  rp, fp;
  logic [PERIOD_BITS:0]    sum;

  // Restoring division, one quotient bit per cycle; the dividend is
  // diff << FRAC_BITS, so the quotient always fits PERIOD_BITS.
  assign divisor  = (state_q == ST_RISE) ? job_q.rise_cnt - 1'b1 : job_q.fall_cnt - 1'b1;
  assign shifted  = {rem_q, div_q[PERIOD_BITS-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign rem_next = ge ? COUNT_BITS'(shifted - {1'b0, divisor}) : shifted[COUNT_BITS-1:0];
  assign div_next = {div_q[PERIOD_BITS-2:0], ge};

  assign pop_o    = (state_q == ST_IDLE) && job_avail_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (job_avail_i) state_d = ST_RISE;
      ST_RISE: if (step_q == LAST_STEP) state_d = ST_FALL;
      ST_FALL: if (step_q == LAST_STEP) state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RISE || state_q == ST_FALL) begin
        step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      div_q <= {job_i.rise_diff, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (state_q == ST_RISE) begin
      if (step_q == LAST_STEP) begin
        rise_quo_q <= div_next;
        div_q      <= {job_q.fall_diff, {FRAC_BITS{1'b0}}};
        rem_q      <= '0;
      end else begin
        div_q <= div_next;
        rem_q <= rem_next;
      end
    end else if (state_q == ST_FALL) begin
      if (step_q == LAST_STEP) begin
        fall_quo_q <= div_next;
      end
      div_q <= div_next;
      rem_q <= rem_next;
    end
    if (load_out) begin
      out_q <= result;
    end
  end

  always_comb begin
    rise_ok   = job_q.rise_cnt >= TWO;
    fall_ok   = !job_q.hyst && (job_q.fall_cnt >= TWO);
    res_valid = rise_ok && (job_q.hyst || fall_ok);
    rp        = rise_ok ? rise_quo_q : '0;
    fp        = fall_ok ? fall_quo_q : '0;
    sum       = {1'b0, rp} + {1'b0, fp};
    result.rise_period  = rp;
    result.fall_period  = fp;
    result.rise_edges   = EDGE_BITS'(job_q.rise_cnt);
    result.fall_edges   = job_q.hyst ? '0 : EDGE_BITS'(job_q.fall_cnt);
    result.period_valid = res_valid;
    if (!res_valid) begin
      result.mean_period = '0;
    end else if (job_q.hyst) begin
      result.mean_period = rp;
    end else begin
      result.mean_period = sum[PERIOD_BITS:1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/level_crossing_period_meter.sv -----
// Top level of the level-crossing period meter.
//
// Samples of a record enter on in_valid_i/in_data_i, one beat per cycle,
// held off by in_stall_o only while the record queue is full. The beat that
// carries last_sample closes the record: its counts and time spans go into a
// queue of FIFO_DEPTH entries and the record state clears at once, so the
// next record may start in the following cycle.
// A serial divider takes one record from the queue and works out both mean
// periods on one shared divider, one quotient bit per cycle; it takes a
// new record only after the last result is loaded. The result appears on
// out_valid_o/out_data_o when both divisions are done and stays there while
// out_stall_i is high; the divider may finish the next record and wait.
// Configuration writes on cfg_valid_i/cfg_index_i/cfg_data_i are always
// taken (cfg_ready_o is high); unknown indices are dropped. Write only when
// the block is idle.
// Reset clears the registers to zero, the record state and the queue.
module level_crossing_period_meter #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lcpm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [lcpm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lcpm_pkg::lcpm_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lcpm_pkg::lcpm_out_t                  out_data_o
);
  import lcpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  lcpm_job_t          push_job, pop_job;
  logic               push, pop, q_full, q_empty;
  logic [CNT_W-1:0]   q_count;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  lcpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  lcpm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  lcpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CNT_W'(FIFO_DEPTH))
    else $error("record queue count beyond its depth");

  a_valid_edges : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.period_valid) |-> (out_data_o.rise_edges >= EDGE_BITS'(2)))
    else $error("valid period with fewer than two rising crossings");

  a_mean_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.period_valid) |-> (out_data_o.mean_period == '0))
    else $error("mean period given for an invalid record");

  a_queue_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_empty && !push) |=> (q_count == '0 || $past(push)))
    else $error("record queue filled without a push");

endmodule
